// ===== rtl/core/lfrt_pkg.sv =====
// ----------------------------------------------------------------------------
// lfrt_pkg
// Shared types and constants for the longest free run tracker: field widths,
// bitmap word geometry, sequencer states and histogram request encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package lfrt_pkg;

	// field widths
	localparam int VAL_W  = 10;
	localparam int RUN_W  = 11;

	// bitmap word geometry
	localparam int WORD_W = 32;
	localparam int OFF_W  = 5;
	localparam int CUT_W  = OFF_W + 1;
	localparam int WIDX_W = VAL_W - OFF_W;

	// storage defaults and the largest range the value field can address
	localparam int NUM_SLOTS_DEF = 1024;
	localparam int MAX_RANGE     = 2 ** VAL_W;
	localparam logic [VAL_W-1:0] TOP_RESET = VAL_W'(MAX_RANGE - 1);

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TEST,
		ST_LSCAN,
		ST_RSCAN,
		ST_UPD,
		ST_INCL,
		ST_INCR,
		ST_RDMAX,
		ST_WALK,
		ST_DONE
	} lfrt_state_t;

	// histogram operations
	typedef enum logic [1:0] {
		HOP_READ,
		HOP_INC,
		HOP_DEC,
		HOP_SET
	} hist_op_t;

	typedef struct packed {
		logic     en;
		hist_op_t op;
		logic     set_one;
	} hist_req_t;

	// nearest deleted bits inside the word just read
	typedef struct packed {
		logic             down_hit;
		logic [OFF_W-1:0] down_pos;
		logic             up_hit;
		logic [OFF_W-1:0] up_pos;
	} bm_probe_t;

endpackage

`default_nettype wire

// ===== rtl/core/lfrt_if.sv =====
// ----------------------------------------------------------------------------
// lfrt_if
// Valid/ready channels of the tracker: deletion requests in, run lengths out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfrt_in_if;
	logic                        valid;
	logic                        ready;
	logic [lfrt_pkg::VAL_W-1:0]  removed_value;

	modport source (output valid, output removed_value, input ready);
	modport sink   (input valid, input removed_value, output ready);
endinterface

interface lfrt_out_if;
	logic                        valid;
	logic                        ready;
	logic [lfrt_pkg::RUN_W-1:0]  longest_run;
	logic                        out_of_range;

	modport source (output valid, output longest_run, output out_of_range, input ready);
	modport sink   (input valid, input longest_run, input out_of_range, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfrt_bitmap.sv =====
// ----------------------------------------------------------------------------
// lfrt_bitmap
// Deletion bitmap held as 32-bit words in a synchronous memory, with the
// in-word search for the nearest deleted bit below and above a cut point.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrt_bitmap #(
	parameter int NWORDS  = 32,
	parameter int WADDR_W = 5
) (
	input  wire logic                              clk,
	input  wire logic                              rd_en,
	input  wire logic [WADDR_W-1:0]                rd_addr,
	input  wire logic                              wr_en,
	input  wire logic [WADDR_W-1:0]                wr_addr,
	input  wire logic [lfrt_pkg::WORD_W-1:0]       wr_data,
	input  wire logic [lfrt_pkg::CUT_W-1:0]        down_cut,
	input  wire logic [lfrt_pkg::CUT_W-1:0]        up_cut,
	output logic [lfrt_pkg::WORD_W-1:0]            rd_word,
	output lfrt_pkg::bm_probe_t                    probe
);

	logic [lfrt_pkg::WORD_W-1:0] mem [NWORDS];
	logic [lfrt_pkg::WORD_W-1:0] rd_word_q;

	// word memory, one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	assign rd_word = rd_word_q;

	// highest set bit below down_cut, lowest set bit at or above up_cut
	always_comb begin
		probe = '0;
		for (int i = 0; i < lfrt_pkg::WORD_W; i++) begin
			if (rd_word_q[i] && (lfrt_pkg::CUT_W'(i) < down_cut)) begin
				probe.down_hit = 1'b1;
				probe.down_pos = lfrt_pkg::OFF_W'(i);
			end
		end
		for (int i = lfrt_pkg::WORD_W - 1; i >= 0; i--) begin
			if (rd_word_q[i] && (lfrt_pkg::CUT_W'(i) >= up_cut)) begin
				probe.up_hit = 1'b1;
				probe.up_pos = lfrt_pkg::OFF_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lfrt_hist.sv =====
// ----------------------------------------------------------------------------
// lfrt_hist
// Run length histogram in a synchronous memory. Increment and decrement are
// read-modify-write, a read then a write-back, with forwarding so back to back requests
// to the same length see each other's results.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrt_hist #(
	parameter int DEPTH = 1025,
	parameter int AW    = 11
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lfrt_pkg::hist_req_t  req,
	input  wire logic [AW-1:0]        addr,
	output logic [AW-1:0]             count
);

	logic [AW-1:0] mem [DEPTH];
	logic [AW-1:0] rd_q;
	logic          rd_issue;
	logic          rmw_s1;
	logic          inc_s1;
	logic [AW-1:0] addr_s1;
	logic          fwd_s1;
	logic [AW-1:0] fwd_data_s1;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] wr_data;

	assign rd_issue = req.en && (req.op != lfrt_pkg::HOP_SET);

	// memory array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_issue) begin
			rd_q <= mem[addr];
		end
	end

	// second half of a read-modify-write, and same-entry forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmw_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			rmw_s1 <= rd_issue &&
				((req.op == lfrt_pkg::HOP_INC) || (req.op == lfrt_pkg::HOP_DEC));
			fwd_s1 <= rd_issue && wr_en && (wr_addr == addr);
		end
	end

	always_ff @(posedge clk) begin
		inc_s1      <= (req.op == lfrt_pkg::HOP_INC);
		addr_s1     <= addr;
		fwd_data_s1 <= wr_data;
	end

	assign count = fwd_s1 ? fwd_data_s1 : rd_q;

	// write port: modify step has priority over a direct set
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr;
		wr_data = AW'(req.set_one);
		if (rmw_s1) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1;
			if (inc_s1) begin
				wr_data = count + AW'(1);
			end else if (count != '0) begin
				wr_data = count - AW'(1);
			end else begin
				wr_data = count;
			end
		end else if (req.en && (req.op == lfrt_pkg::HOP_SET)) begin
			wr_en = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/longest_free_run_tracker.sv =====
// Steps: an ignored (out of range) value goes straight to the output register, a
// repeated deletion after its own bitmap word read, a fresh deletion after that read, L and R
// extra bitmap words read on each side (one 32-bit word a cycle), the histogram update and W
// histogram steps the maximum falls (one memory read a cycle).
// Throughput: one request in work at a time; the next is taken once the result
// sits in the output register. Reset and every top_value write start a clearing
// pass over the histogram and bitmap during which no request is taken.
// ----------------------------------------------------------------------------
// longest_free_run_tracker
// Tracks the values 0..top_value as they are deleted and reports the length
// of the longest run still present, using a word bitmap and a run length
// histogram held in synchronous memories.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_free_run_tracker #(
	parameter int NUM_SLOTS = lfrt_pkg::NUM_SLOTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [lfrt_pkg::VAL_W-1:0]  cfg_wdata,
	lfrt_in_if.sink                          deletion,
	lfrt_out_if.source                       answer
);

	localparam int RANGE   = (NUM_SLOTS < lfrt_pkg::MAX_RANGE) ? NUM_SLOTS
	                                                            : lfrt_pkg::MAX_RANGE;
	localparam int DEPTH   = RANGE + 1;
	localparam int LEN_W   = $clog2(DEPTH);
	localparam int NWORDS  = (RANGE + lfrt_pkg::WORD_W - 1) / lfrt_pkg::WORD_W;
	localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	localparam int VW = lfrt_pkg::VAL_W;
	localparam int RW = lfrt_pkg::RUN_W;
	localparam int XW = lfrt_pkg::WIDX_W;
	localparam int OW = lfrt_pkg::OFF_W;
	localparam int CW = lfrt_pkg::CUT_W;

	lfrt_pkg::lfrt_state_t state_q, state_d;

	logic [VW-1:0]    top_q, top_d;
	logic [VW-1:0]    y_q, y_d;
	logic             flag_q, flag_d;
	logic [XW-1:0]    scan_w_q, scan_w_d;
	logic [RW-1:0]    lb1_q, lb1_d;
	logic [RW-1:0]    rb_q, rb_d;
	logic             rdone_q, rdone_d;
	logic             ldone;
	logic [lfrt_pkg::WORD_W-1:0] orig_q, orig_d;
	logic [LEN_W-1:0] cur_q, cur_d;
	logic [LEN_W-1:0] clr_q, clr_d;

	logic             out_valid_q;
	logic [RW-1:0]    out_run_q;
	logic             out_flag_q;
	logic             out_load;
	logic             in_ready;

	logic [VW-1:0]    t_eff;
	logic [RW-1:0]    tp1;
	logic [OW-1:0]    off;
	logic [XW-1:0]    w0;
	logic [XW-1:0]    t_w;
	logic [RW-1:0]    left_len;
	logic [RW-1:0]    right_len;
	logic [RW-1:0]    whole_len;
	logic [XW-1:0]    probe_w;
	logic [RW-1:0]    down_abs;
	logic [RW-1:0]    up_abs;

	// bitmap and histogram ports
	logic                        bm_rd_en;
	logic [XW-1:0]               bm_rd_w;
	logic                        bm_wr_en;
	logic [WADDR_W-1:0]          bm_wr_addr;
	logic [lfrt_pkg::WORD_W-1:0] bm_wr_data;
	logic [CW-1:0]               down_cut;
	logic [CW-1:0]               up_cut;
	logic [lfrt_pkg::WORD_W-1:0] bm_word;
	lfrt_pkg::bm_probe_t         probe;
	lfrt_pkg::hist_req_t         h_req;
	logic [LEN_W-1:0]            h_addr;
	logic [LEN_W-1:0]            h_count;

	lfrt_bitmap #(
		.NWORDS  (NWORDS),
		.WADDR_W (WADDR_W)
	) u_bitmap (
		.clk      (clk),
		.rd_en    (bm_rd_en),
		.rd_addr  (WADDR_W'(bm_rd_w)),
		.wr_en    (bm_wr_en),
		.wr_addr  (bm_wr_addr),
		.wr_data  (bm_wr_data),
		.down_cut (down_cut),
		.up_cut   (up_cut),
		.rd_word  (bm_word),
		.probe    (probe)
	);

	lfrt_hist #(
		.DEPTH (DEPTH),
		.AW    (LEN_W)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (h_req),
		.addr   (h_addr),
		.count  (h_count)
	);

	// effective top and derived positions
	assign t_eff = (top_q > VW'(RANGE - 1)) ? VW'(RANGE - 1) : top_q;
	assign tp1   = {1'b0, t_eff} + RW'(1);
	assign off   = y_q[OW-1:0];
	assign w0    = y_q[VW-1:OW];
	assign t_w   = t_eff[VW-1:OW];

	// lengths of the run being split and of its two pieces
	assign left_len  = {1'b0, y_q} - lb1_q;
	assign right_len = rb_q - {1'b0, y_q} - RW'(1);
	assign whole_len = rb_q - lb1_q;

	// word index of the bitmap word currently on the read port
	assign probe_w = (state_q == lfrt_pkg::ST_TEST) ? w0 : scan_w_q;

	// absolute positions of the bits found in the word just read
	assign down_abs = {1'b0, probe_w, probe.down_pos} + RW'(1);
	assign up_abs   = {1'b0, probe_w, probe.up_pos};

	// state register and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfrt_pkg::ST_CLEAR;
			top_q   <= lfrt_pkg::TOP_RESET;
			clr_q   <= '0;
			cur_q   <= '0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			clr_q   <= clr_d;
			cur_q   <= cur_d;
		end
	end

	always_ff @(posedge clk) begin
		y_q      <= y_d;
		flag_q   <= flag_d;
		scan_w_q <= scan_w_d;
		lb1_q    <= lb1_d;
		rb_q     <= rb_d;
		rdone_q  <= rdone_d;
		orig_q   <= orig_d;
	end

	// sequencer: next state, memory requests and datapath updates
	always_comb begin
		state_d    = state_q;
		top_d      = top_q;
		clr_d      = clr_q;
		cur_d      = cur_q;
		y_d        = y_q;
		flag_d     = flag_q;
		scan_w_d   = scan_w_q;
		lb1_d      = lb1_q;
		rb_d       = rb_q;
		rdone_d    = rdone_q;
		orig_d     = orig_q;
		ldone      = 1'b0;
		in_ready   = 1'b0;
		out_load   = 1'b0;
		bm_rd_en   = 1'b0;
		bm_rd_w    = w0;
		bm_wr_en   = 1'b0;
		bm_wr_addr = WADDR_W'(w0);
		bm_wr_data = orig_q | (lfrt_pkg::WORD_W'(1) << off);
		down_cut   = {1'b0, off};
		up_cut     = {1'b0, off} + CW'(1);
		h_req      = '0;
		h_addr     = cur_q;

		unique case (state_q)
			lfrt_pkg::ST_CLEAR: begin
				h_req.en      = 1'b1;
				h_req.op      = lfrt_pkg::HOP_SET;
				h_req.set_one = (clr_q == LEN_W'(tp1));
				h_addr        = clr_q;
				if (clr_q < LEN_W'(NWORDS)) begin
					bm_wr_en   = 1'b1;
					bm_wr_addr = WADDR_W'(clr_q);
					bm_wr_data = '0;
				end
				cur_d = LEN_W'(tp1);
				if (clr_q == LEN_W'(RANGE)) begin
					state_d = lfrt_pkg::ST_IDLE;
				end else begin
					clr_d = clr_q + LEN_W'(1);
				end
			end
			lfrt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (deletion.valid) begin
					y_d    = deletion.removed_value;
					flag_d = (deletion.removed_value > t_eff);
					if (deletion.removed_value > t_eff) begin
						state_d = lfrt_pkg::ST_DONE;
					end else begin
						bm_rd_en = 1'b1;
						bm_rd_w  = deletion.removed_value[VW-1:OW];
						state_d  = lfrt_pkg::ST_TEST;
					end
				end
			end
			lfrt_pkg::ST_TEST: begin
				orig_d = bm_word;
				if (bm_word[off]) begin
					state_d = lfrt_pkg::ST_DONE;
				end else begin
					// left edge inside this word or at the bottom of the range
					if (probe.down_hit) begin
						lb1_d = down_abs;
						ldone = 1'b1;
					end else if (w0 == '0) begin
						lb1_d = '0;
						ldone = 1'b1;
					end
					// right edge inside this word or at the top of the range
					rdone_d = 1'b0;
					if (probe.up_hit) begin
						rb_d    = (up_abs < tp1) ? up_abs : tp1;
						rdone_d = 1'b1;
					end else if (w0 == t_w) begin
						rb_d    = tp1;
						rdone_d = 1'b1;
					end
					if (!ldone) begin
						bm_rd_en = 1'b1;
						bm_rd_w  = w0 - XW'(1);
						scan_w_d = w0 - XW'(1);
						state_d  = lfrt_pkg::ST_LSCAN;
					end else if (!rdone_d) begin
						bm_rd_en = 1'b1;
						bm_rd_w  = w0 + XW'(1);
						scan_w_d = w0 + XW'(1);
						state_d  = lfrt_pkg::ST_RSCAN;
					end else begin
						state_d = lfrt_pkg::ST_UPD;
					end
				end
			end
			lfrt_pkg::ST_LSCAN: begin
				down_cut = CW'(lfrt_pkg::WORD_W);
				if (probe.down_hit) begin
					lb1_d = down_abs;
					ldone = 1'b1;
				end else if (scan_w_q == '0) begin
					lb1_d = '0;
					ldone = 1'b1;
				end else begin
					bm_rd_en = 1'b1;
					bm_rd_w  = scan_w_q - XW'(1);
					scan_w_d = scan_w_q - XW'(1);
				end
				if (ldone) begin
					if (rdone_q) begin
						state_d = lfrt_pkg::ST_UPD;
					end else begin
						bm_rd_en = 1'b1;
						bm_rd_w  = w0 + XW'(1);
						scan_w_d = w0 + XW'(1);
						state_d  = lfrt_pkg::ST_RSCAN;
					end
				end
			end
			lfrt_pkg::ST_RSCAN: begin
				up_cut = '0;
				if (probe.up_hit) begin
					rb_d    = (up_abs < tp1) ? up_abs : tp1;
					state_d = lfrt_pkg::ST_UPD;
				end else if (scan_w_q == t_w) begin
					rb_d    = tp1;
					state_d = lfrt_pkg::ST_UPD;
				end else begin
					bm_rd_en = 1'b1;
					bm_rd_w  = scan_w_q + XW'(1);
					scan_w_d = scan_w_q + XW'(1);
				end
			end
			lfrt_pkg::ST_UPD: begin
				// mark the value and retire the run it split
				bm_wr_en   = 1'b1;
				bm_wr_addr = WADDR_W'(w0);
				h_req.en   = 1'b1;
				h_req.op   = lfrt_pkg::HOP_DEC;
				h_addr     = LEN_W'(whole_len);
				state_d    = lfrt_pkg::ST_INCL;
			end
			lfrt_pkg::ST_INCL: begin
				h_req.en = (left_len != '0);
				h_req.op = lfrt_pkg::HOP_INC;
				h_addr   = LEN_W'(left_len);
				state_d  = lfrt_pkg::ST_INCR;
			end
			lfrt_pkg::ST_INCR: begin
				h_req.en = (right_len != '0);
				h_req.op = lfrt_pkg::HOP_INC;
				h_addr   = LEN_W'(right_len);
				state_d  = lfrt_pkg::ST_RDMAX;
			end
			lfrt_pkg::ST_RDMAX: begin
				h_req.en = 1'b1;
				h_req.op = lfrt_pkg::HOP_READ;
				h_addr   = cur_q;
				state_d  = lfrt_pkg::ST_WALK;
			end
			lfrt_pkg::ST_WALK: begin
				// step the maximum down until a length with a nonzero count
				if ((cur_q == '0) || (h_count != '0)) begin
					state_d = lfrt_pkg::ST_DONE;
				end else begin
					cur_d    = cur_q - LEN_W'(1);
					h_req.en = 1'b1;
					h_req.op = lfrt_pkg::HOP_READ;
					h_addr   = cur_q - LEN_W'(1);
				end
			end
			lfrt_pkg::ST_DONE: begin
				if (!out_valid_q || answer.ready) begin
					out_load = 1'b1;
					state_d  = lfrt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lfrt_pkg::ST_CLEAR;
				clr_d   = '0;
			end
		endcase

		// a register write restarts from the reset picture of the new range
		if (cfg_we) begin
			top_d   = cfg_wdata;
			clr_d   = '0;
			state_d = lfrt_pkg::ST_CLEAR;
		end
	end

	assign deletion.ready = in_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (answer.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_run_q  <= RW'(cur_q);
			out_flag_q <= flag_q;
		end
	end

	assign answer.valid        = out_valid_q;
	assign answer.longest_run  = out_run_q;
	assign answer.out_of_range = out_flag_q;

	// the maximum only rises during a clearing pass
	a_max_falls: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) != lfrt_pkg::ST_CLEAR) |-> (cur_q <= $past(cur_q)))
		else $error("longest run grew outside a clearing pass");

	// the maximum never exceeds the size of the tracked range
	a_max_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lfrt_pkg::ST_CLEAR) |-> (RW'(cur_q) <= tp1))
		else $error("longest run beyond range size");

	// the bounds found by the scans enclose the deleted value
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lfrt_pkg::ST_UPD) |->
		((lb1_q <= {1'b0, y_q}) && (rb_q > {1'b0, y_q}) && (rb_q <= tp1)))
		else $error("run bounds do not enclose the deleted value");

endmodule

`default_nettype wire

// ===== bench/run_board_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_board_pkg
// Scoreboard for the longest free run tracker: keeps its own deletion map,
// run length histogram and running maximum, predicts the answer of every
// accepted deletion request and checks answers in order.
// ----------------------------------------------------------------------------

package run_board_pkg;

	import lfrt_pkg::*;

	// one predicted answer
	typedef struct packed {
		logic [RUN_W-1:0] run;
		logic             oor;
	} removal_answer_t;

	class free_run_board;

		bit              gone [NUM_SLOTS_DEF];
		int unsigned     run_tally [NUM_SLOTS_DEF + 1];
		int unsigned     longest;
		int unsigned     top_eff;
		removal_answer_t awaited [$];

		int mismatches  = 0;
		int fresh_cnt   = 0;
		int repeat_cnt  = 0;
		int ignored_cnt = 0;
		int empty_cnt   = 0;
		int checked_cnt = 0;

		// back to the cleared form for a new top value
		function void restart(input logic [VAL_W-1:0] top);
			top_eff = (top > NUM_SLOTS_DEF - 1) ? NUM_SLOTS_DEF - 1 : top;
			foreach (gone[k]) gone[k] = 1'b0;
			foreach (run_tally[k]) run_tally[k] = 0;
			run_tally[top_eff + 1] = 1;
			longest = top_eff + 1;
		endfunction

		// apply one accepted deletion and queue the answer it must give
		function void note_removal(input logic [VAL_W-1:0] v);
			int unsigned     lo_len;
			int unsigned     hi_len;
			int unsigned     whole;
			int unsigned     i;
			removal_answer_t ans;
			ans.oor = 1'b0;
			if (v > top_eff) begin
				ans.oor = 1'b1;
				ignored_cnt++;
			end else if (gone[v]) begin
				repeat_cnt++;
			end else begin
				fresh_cnt++;
				// present neighbours on each side bound the run being split
				lo_len = 0;
				i = v;
				while (i > 0 && !gone[i - 1]) begin
					lo_len++;
					i--;
				end
				hi_len = 0;
				i = v + 1;
				while (i <= top_eff && !gone[i]) begin
					hi_len++;
					i++;
				end
				whole = lo_len + hi_len + 1;
				gone[v] = 1'b1;
				if (whole <= NUM_SLOTS_DEF && run_tally[whole] > 0)
					run_tally[whole]--;
				if (lo_len > 0)
					run_tally[lo_len]++;
				if (hi_len > 0)
					run_tally[hi_len]++;
				// maximum only walks down
				if (longest > NUM_SLOTS_DEF)
					longest = NUM_SLOTS_DEF;
				while (longest > 0 && run_tally[longest] == 0)
					longest--;
			end
			ans.run = RUN_W'(longest);
			if (longest == 0)
				empty_cnt++;
			awaited.push_back(ans);
		endfunction

		// compare one accepted answer with the oldest prediction
		function void check_answer(input logic [RUN_W-1:0] run, input logic oor);
			removal_answer_t want;
			checked_cnt++;
			if (awaited.size() == 0) begin
				$display("%0t: answer with no pending removal: longest_run %0d out_of_range %0d",
					$time, run, oor);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (run !== want.run) begin
				$display("%0t: longest_run mismatch: expected %0d, actual %0d",
					$time, want.run, run);
				mismatches++;
			end
			if (oor !== want.oor) begin
				$display("%0t: out_of_range mismatch: expected %0d, actual %0d",
					$time, want.oor, oor);
				mismatches++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// anything still queued at the end never got its answer
		function void report_leftovers();
			if (awaited.size() != 0) begin
				$display("%0t: %0d answers never arrived, oldest expected longest_run %0d",
					$time, awaited.size(), awaited[0].run);
				mismatches += awaited.size();
			end
		endfunction

	endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives deletion requests into the longest free run tracker under random
// handshake gaps and top value settings, and checks every answer against a
// scoreboard that tracks the same runs.
// ----------------------------------------------------------------------------

module tb_top;

	import lfrt_pkg::*;
	import run_board_pkg::*;

	localparam int RESET_CYCLES  = 4;
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_TARGET = 850;
	localparam int RANDOM_LEN    = 150;
	localparam int SWEEP_MAX_TOP = 300;
	localparam int HOLD_AT       = 150;
	localparam int HOLD_CYCLES   = 400;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [VAL_W-1:0] cfg_wdata;

	lfrt_in_if  del_ch ();
	lfrt_out_if ans_ch ();

	free_run_board board = new;

	int sent_total    = 0;
	int in_range_sent = 0;
	int tops_used     = 0;
	int cycle_count   = 0;

	longest_free_run_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.deletion  (del_ch),
		.answer    (ans_ch)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// offer one deletion request and note it once accepted
	task automatic offer_removal(input logic [VAL_W-1:0] v);
		int gap;
		gap = (((sent_total / 40) % 4) == 3) ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			del_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		del_ch.valid <= 1'b1;
		del_ch.removed_value <= v;
		do @(posedge clk); while (!(del_ch.valid && del_ch.ready));
		board.note_removal(v);
		sent_total++;
	endtask

	// stop offering and wait until every answer is in
	task automatic settle();
		del_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// top value write, only with the block idle
	task automatic write_top(input logic [VAL_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		board.restart(v);
		cfg_we <= 1'b0;
		tops_used++;
	endtask

	// answer side: random ready gaps, calm stretches and one long hold
	initial begin : answer_sink
		int gap;
		int taken;
		taken = 0;
		ans_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		ans_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (ans_ch.valid && ans_ch.ready) begin
				board.check_answer(ans_ch.longest_run, ans_ch.out_of_range);
				taken++;
				if (taken == HOLD_AT)
					gap = HOLD_CYCLES;
				else if (((taken / 48) % 3) == 2)
					gap = 0;
				else
					gap = $urandom_range(0, 4);
				if (gap > 0) begin
					ans_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
					ans_ch.ready <= 1'b1;
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		logic [VAL_W-1:0] top;
		logic [VAL_W-1:0] tmp;
		logic [VAL_W-1:0] order [$];
		bit               sweep;
		int               phase;
		int               j;
		int               k;
		int               roll;

		board.restart(TOP_RESET);
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		del_ch.valid <= 1'b0;
		del_ch.removed_value <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full range from reset: ends, middle, repeat, neighbours of a hole
		offer_removal(10'd0);
		offer_removal(10'd1023);
		offer_removal(10'd512);
		offer_removal(10'd512);
		offer_removal(10'd511);
		offer_removal(10'd513);
		offer_removal(10'd1);
		offer_removal(10'd1022);

		// single value range: emptied, then above the top
		write_top(10'd0);
		offer_removal(10'd0);
		offer_removal(10'd0);
		offer_removal(10'd1);
		offer_removal(10'd1023);

		// two values
		write_top(10'd1);
		offer_removal(10'd1);
		offer_removal(10'd1023);
		offer_removal(10'd0);
		offer_removal(10'd1);

		// range just over one bitmap word
		write_top(10'd33);
		offer_removal(10'd32);
		offer_removal(10'd31);
		offer_removal(10'd0);
		offer_removal(10'd33);
		offer_removal(10'd34);
		offer_removal(10'd16);

		// random phases: small ranges swept to empty, large ones sampled
		phase = 0;
		while (in_range_sent < RANDOM_TARGET) begin
			case (phase % 10)
				0: top = TOP_RESET;
				1: top = 10'd0;
				2: top = 10'd1;
				3: top = 10'd2;
				4: top = 10'd31;
				5: top = 10'd32;
				6: top = 10'd33;
				7: top = 10'd64;
				8: top = VAL_W'($urandom_range(3, SWEEP_MAX_TOP));
				default: top = VAL_W'($urandom_range(SWEEP_MAX_TOP + 1, MAX_RANGE - 2));
			endcase
			sweep = (top <= SWEEP_MAX_TOP);
			write_top(top);
			order.delete();
			if (sweep) begin
				// shuffled order of the whole range
				for (j = 0; j <= top; j++)
					order.push_back(VAL_W'(j));
				for (j = order.size() - 1; j > 0; j--) begin
					k = $urandom_range(0, j);
					tmp = order[j];
					order[j] = order[k];
					order[k] = tmp;
				end
			end else begin
				for (j = 0; j < RANDOM_LEN; j++)
					order.push_back(VAL_W'($urandom_range(0, top)));
			end
			for (j = 0; j < order.size(); j++) begin
				roll = $urandom_range(0, 99);
				// noise above the top, or a repeat of an earlier value
				if (roll < 8 && top != TOP_RESET)
					offer_removal(VAL_W'($urandom_range(top + 1, MAX_RANGE - 1)));
				else if (roll < 14) begin
					offer_removal(order[$urandom_range(0, j)]);
					in_range_sent++;
				end
				offer_removal(order[j]);
				in_range_sent++;
			end
			phase++;
		end

		settle();
		$display("covered %0d requests: %0d fresh deletions, %0d repeats, %0d above the top",
			sent_total, board.fresh_cnt, board.repeat_cnt, board.ignored_cnt);
		$display("over %0d top value writes, %0d answers with every value deleted",
			tops_used, board.empty_cnt);
		board.report_leftovers();
		if (board.mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
